### rtl/eabv_pkg.sv
// Shared types, constants and fixed-point helpers for the Euler angle to basis vector block.
// No dependencies; used by every module in rtl/.
`timescale 1ns / 1ps

package eabv_pkg;

  // Pipeline shape: sine/cosine stages, then basis stages.
  localparam int ScStg  = 7;
  localparam int BsStg  = 4;
  localparam int NumStg = ScStg + BsStg;

  // Angle units: 1/64 degree, so half a turn is 11520 units.
  localparam int HalfTurn = 11520;
  localparam int RedT1    = HalfTurn / 2;
  localparam int RedT2    = (3 * HalfTurn) / 2;
  localparam int RedT3    = (5 * HalfTurn) / 2;

  // pi / HalfTurn in Q30, and the polynomial coefficients in Q30.
  localparam logic signed [31:0] RadQ30 = 32'sd292818;
  localparam logic signed [31:0] SinA   = 32'sd8132786;
  localparam logic signed [31:0] SinB   = -32'sd178055431;
  localparam logic signed [31:0] SinC   = 32'sd1073496375;
  localparam logic signed [31:0] CosA   = 32'sd39953211;
  localparam logic signed [31:0] CosB   = -32'sd532997206;
  localparam logic signed [31:0] CosC   = 32'sd1073290332;

  typedef struct packed {
    logic signed [15:0] pitch_deg;
    logic signed [15:0] yaw_deg;
    logic signed [15:0] roll_deg;
  } in_t;

  typedef struct packed {
    logic signed [15:0] fwd_x;
    logic signed [15:0] fwd_y;
    logic signed [15:0] fwd_z;
    logic signed [15:0] right_x;
    logic signed [15:0] right_y;
    logic signed [15:0] right_z;
    logic signed [15:0] up_x;
    logic signed [15:0] up_y;
    logic signed [15:0] up_z;
  } out_t;

  // Sine and cosine of one angle, Q30.
  typedef struct packed {
    logic signed [31:0] sn;
    logic signed [31:0] cs;
  } sc_t;

  // Q60 product back to Q30, half away from zero.
  function automatic logic signed [33:0] rnd_q30(input logic signed [63:0] p);
    logic signed [63:0] t;
    t = p + (p[63] ? 64'sd536870911 : 64'sd536870912);
    return 34'(t >>> 30);
  endfunction

  // Q30 by Q30 multiply, rounded to Q30.
  function automatic logic signed [31:0] mulq(input logic signed [31:0] a,
                                               input logic signed [31:0] b);
    logic signed [63:0] p;
    logic signed [33:0] r;
    p = 64'(a) * 64'(b);
    r = rnd_q30(p);
    return 32'(r);
  endfunction

  // Q30 to Q2.14, half away from zero, saturating.
  function automatic logic signed [15:0] to_q14(input logic signed [33:0] v);
    logic signed [33:0] t;
    logic signed [17:0] q;
    logic signed [15:0] res;
    t = v + (v[33] ? 34'sd32767 : 34'sd32768);
    q = 18'(t >>> 16);
    if (q > 18'sd32767) begin
      res = 16'sh7fff;
    end else if (q < -18'sd32768) begin
      res = 16'sh8000;
    end else begin
      res = 16'(q);
    end
    return res;
  endfunction

endpackage

### rtl/eabv_sincos.sv
// Seven-stage sine/cosine pipeline for one angle: reduction, radians, polynomials, sign fix.
// Depends on eabv_pkg; stage enables come from the top-level flow control.
`timescale 1ns / 1ps

module eabv_sincos import eabv_pkg::*; (
  input  logic                    clk_i,
  input  logic [ScStg-1:0]        en_i,
  input  logic signed [15:0]      ang_i,
  output sc_t                     sc_o
);

  // stage 1: reduce by nearest half turn
  logic signed [16:0] a_ext;
  logic [16:0]        mag;
  logic [1:0]         kmag;
  logic [16:0]        offs;
  logic signed [17:0] r_wide;
  logic signed [13:0] r1_d, r1_q;
  logic               odd1_q;

  always_comb begin
    a_ext = 17'(ang_i);
    mag   = a_ext[16] ? 17'(-a_ext) : 17'(a_ext);
    if (mag >= 17'(RedT3)) begin
      kmag = 2'd3;
    end else if (mag >= 17'(RedT2)) begin
      kmag = 2'd2;
    end else if (mag >= 17'(RedT1)) begin
      kmag = 2'd1;
    end else begin
      kmag = 2'd0;
    end
    case (kmag)
      2'd0:    offs = 17'd0;
      2'd1:    offs = 17'(HalfTurn);
      2'd2:    offs = 17'(2 * HalfTurn);
      default: offs = 17'(3 * HalfTurn);
    endcase
    r_wide = a_ext[16] ? 18'(a_ext) + $signed({1'b0, offs})
                       : 18'(a_ext) - $signed({1'b0, offs});
    r1_d   = 14'(r_wide);
  end

  // stage 2: to radians, Q30
  logic signed [33:0] p2;
  logic signed [31:0] x2_q;
  logic               odd2_q;
  assign p2 = 34'(r1_q) * 34'(RadQ30);

  // stage 3: x squared
  logic signed [63:0] p3;
  logic signed [33:0] m3;
  logic signed [31:0] x3_q;
  logic signed [32:0] f3_q;
  logic               odd3_q;
  assign p3 = 64'(x2_q) * 64'(x2_q);
  assign m3 = rnd_q30(p3);

  // stage 4: inner polynomial terms
  logic signed [63:0] p4s, p4c;
  logic signed [33:0] m4s, m4c;
  logic signed [31:0] x4_q, t4_q, c4_q;
  logic signed [32:0] f4_q;
  logic               odd4_q;
  assign p4s = 64'(SinA) * 64'(f3_q);
  assign p4c = 64'(CosA) * 64'(f3_q);
  assign m4s = rnd_q30(p4s);
  assign m4c = rnd_q30(p4c);

  // stage 5: outer polynomial terms
  logic signed [63:0] p5s, p5c;
  logic signed [33:0] m5s, m5c;
  logic signed [31:0] x5_q, t5_q, c5_q;
  logic               odd5_q;
  assign p5s = 64'(f4_q) * 64'(t4_q);
  assign p5c = 64'(f4_q) * 64'(c4_q);
  assign m5s = rnd_q30(p5s);
  assign m5c = rnd_q30(p5c);

  // stage 6: sine = x * poly
  logic signed [63:0] p6;
  logic signed [33:0] m6;
  logic signed [31:0] s6_q, c6_q;
  logic               odd6_q;
  assign p6 = 64'(x5_q) * 64'(t5_q);
  assign m6 = rnd_q30(p6);

  // stage 7: odd multiple of a half turn flips both
  sc_t sc_q;

  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      r1_q   <= r1_d;
      odd1_q <= kmag[0];
    end
    if (en_i[1]) begin
      x2_q   <= 32'(p2);
      odd2_q <= odd1_q;
    end
    if (en_i[2]) begin
      x3_q   <= x2_q;
      f3_q   <= 33'(m3);
      odd3_q <= odd2_q;
    end
    if (en_i[3]) begin
      x4_q   <= x3_q;
      f4_q   <= f3_q;
      t4_q   <= 32'(34'(SinB) + m4s);
      c4_q   <= 32'(34'(CosB) + m4c);
      odd4_q <= odd3_q;
    end
    if (en_i[4]) begin
      x5_q   <= x4_q;
      t5_q   <= 32'(34'(SinC) + m5s);
      c5_q   <= 32'(34'(CosC) + m5c);
      odd5_q <= odd4_q;
    end
    if (en_i[5]) begin
      s6_q   <= 32'(m6);
      c6_q   <= c5_q;
      odd6_q <= odd5_q;
    end
    if (en_i[6]) begin
      sc_q.sn <= odd6_q ? -s6_q : s6_q;
      sc_q.cs <= odd6_q ? -c6_q : c6_q;
    end
  end

  assign sc_o = sc_q;

endmodule

### rtl/eabv_basis.sv
// Four-stage basis assembly: cross products, second-level products, sums, round and saturate.
// Depends on eabv_pkg; fed by three eabv_sincos lanes.
`timescale 1ns / 1ps

module eabv_basis import eabv_pkg::*; (
  input  logic                clk_i,
  input  logic [BsStg-1:0]    en_i,
  input  sc_t                 pch_i,
  input  sc_t                 yaw_i,
  input  sc_t                 rol_i,
  output out_t                out_o
);

  // stage 8: first-level products
  logic signed [31:0] sp8_q, sr8_q, cr8_q;
  logic signed [31:0] spcy8_q, spsy8_q, cpcy8_q, cpsy8_q, srcp8_q, crcp8_q;
  logic signed [31:0] crsy8_q, crcy8_q, srsy8_q, srcy8_q;

  // stage 9: products with sin pitch terms
  logic signed [31:0] sp9_q, cpcy9_q, cpsy9_q, srcp9_q, crcp9_q;
  logic signed [31:0] crsy9_q, crcy9_q, srsy9_q, srcy9_q;
  logic signed [31:0] srspcy9_q, crspcy9_q, srspsy9_q, crspsy9_q;

  // stage 10: Q30 sums, stage 11: output word
  logic signed [33:0] sum10_q [9];
  out_t               out_q;

  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      sp8_q   <= pch_i.sn;
      sr8_q   <= rol_i.sn;
      cr8_q   <= rol_i.cs;
      spcy8_q <= mulq(pch_i.sn, yaw_i.cs);
      spsy8_q <= mulq(pch_i.sn, yaw_i.sn);
      cpcy8_q <= mulq(pch_i.cs, yaw_i.cs);
      cpsy8_q <= mulq(pch_i.cs, yaw_i.sn);
      srcp8_q <= mulq(rol_i.sn, pch_i.cs);
      crcp8_q <= mulq(rol_i.cs, pch_i.cs);
      crsy8_q <= mulq(rol_i.cs, yaw_i.sn);
      crcy8_q <= mulq(rol_i.cs, yaw_i.cs);
      srsy8_q <= mulq(rol_i.sn, yaw_i.sn);
      srcy8_q <= mulq(rol_i.sn, yaw_i.cs);
    end
    if (en_i[1]) begin
      sp9_q     <= sp8_q;
      cpcy9_q   <= cpcy8_q;
      cpsy9_q   <= cpsy8_q;
      srcp9_q   <= srcp8_q;
      crcp9_q   <= crcp8_q;
      crsy9_q   <= crsy8_q;
      crcy9_q   <= crcy8_q;
      srsy9_q   <= srsy8_q;
      srcy9_q   <= srcy8_q;
      srspcy9_q <= mulq(sr8_q, spcy8_q);
      crspcy9_q <= mulq(cr8_q, spcy8_q);
      srspsy9_q <= mulq(sr8_q, spsy8_q);
      crspsy9_q <= mulq(cr8_q, spsy8_q);
    end
    if (en_i[2]) begin
      sum10_q[0] <= 34'(cpcy9_q);
      sum10_q[1] <= 34'(cpsy9_q);
      sum10_q[2] <= 34'sd0 - 34'(sp9_q);
      sum10_q[3] <= 34'(crsy9_q) - 34'(srspcy9_q);
      sum10_q[4] <= 34'sd0 - 34'(srspsy9_q) - 34'(crcy9_q);
      sum10_q[5] <= 34'sd0 - 34'(srcp9_q);
      sum10_q[6] <= 34'(crspcy9_q) + 34'(srsy9_q);
      sum10_q[7] <= 34'(crspsy9_q) - 34'(srcy9_q);
      sum10_q[8] <= 34'(crcp9_q);
    end
    if (en_i[3]) begin
      out_q.fwd_x   <= to_q14(sum10_q[0]);
      out_q.fwd_y   <= to_q14(sum10_q[1]);
      out_q.fwd_z   <= to_q14(sum10_q[2]);
      out_q.right_x <= to_q14(sum10_q[3]);
      out_q.right_y <= to_q14(sum10_q[4]);
      out_q.right_z <= to_q14(sum10_q[5]);
      out_q.up_x    <= to_q14(sum10_q[6]);
      out_q.up_y    <= to_q14(sum10_q[7]);
      out_q.up_z    <= to_q14(sum10_q[8]);
    end
  end

  assign out_o = out_q;

endmodule

### rtl/euler_angles_to_basis_vectors.sv
// Top level: Euler angles to forward/right/up basis vectors, with pipeline flow control.
// Depends on eabv_pkg, eabv_sincos and eabv_basis.
`timescale 1ns / 1ps

// Usage
//   Input channel: valid_i / stall_o carry one word of pitch, yaw and roll in 1/64 degree.
//   Output channel: valid_o / stall_i carry one word of nine Q2.14 basis components.
//   A word moves on a rising edge where valid is high and stall is low.
//   Pipeline: 11 register stages (7 per angle lane for sine/cosine, 4 for products, sums
//   and rounding).
//   Throughput: one word per cycle while the receiver does not stall; every stage holds a
//   registered multiplier (or the reduction compare/add, the sign fix, the sums, or the
//   final round/saturate), and the three angle lanes run side by side.
//   Each stage carries a valid bit and loads whenever it is empty or the stage after it
//   moves on, so bubbles close up and a word is accepted while a result still waits
//   at the output, as long as the pipeline has a free slot.
//   Receiver stall: the output word is held unchanged; stall_o rises only once all
//   11 stages are full and the receiver is stalling.
//   Reset: valid bits clear asynchronously; datapath registers are not reset.
//   No configuration and no state between words.

module euler_angles_to_basis_vectors import eabv_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic valid_i,
  output logic stall_o,
  input  in_t  in_i,
  output logic valid_o,
  input  logic stall_i,
  output out_t out_o
);

  logic [NumStg-1:0] valid_q, valid_d, valid_sh;
  logic [NumStg-1:0] en;

  // load enable per stage: empty, or the next stage is taking our word
  always_comb begin
    en[NumStg-1] = !valid_q[NumStg-1] || !stall_i;
    for (int k = NumStg - 2; k >= 0; k--) begin
      en[k] = !valid_q[k] || en[k+1];
    end
  end

  assign valid_sh = {valid_q[NumStg-2:0], valid_i};
  assign valid_d  = (en & valid_sh) | (~en & valid_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      valid_q <= valid_d;
    end
  end

  assign stall_o = !en[0];
  assign valid_o = valid_q[NumStg-1];

  sc_t pch_sc, yaw_sc, rol_sc;

  eabv_sincos u_sc_pitch (
    .clk_i (clk_i),
    .en_i  (en[ScStg-1:0]),
    .ang_i (in_i.pitch_deg),
    .sc_o  (pch_sc)
  );

  eabv_sincos u_sc_yaw (
    .clk_i (clk_i),
    .en_i  (en[ScStg-1:0]),
    .ang_i (in_i.yaw_deg),
    .sc_o  (yaw_sc)
  );

  eabv_sincos u_sc_roll (
    .clk_i (clk_i),
    .en_i  (en[ScStg-1:0]),
    .ang_i (in_i.roll_deg),
    .sc_o  (rol_sc)
  );

  eabv_basis u_basis (
    .clk_i (clk_i),
    .en_i  (en[NumStg-1:ScStg]),
    .pch_i (pch_sc),
    .yaw_i (yaw_sc),
    .rol_i (rol_sc),
    .out_o (out_o)
  );

  // back-pressure only when the whole pipeline is full and the receiver stalls
  a_stall_full : assert property (@(posedge clk_i) disable iff (!rst_ni)
    stall_o |-> ((&valid_q) && stall_i))
    else $error("input stalled with a free pipeline slot");

  // an accepted word lands in the first stage
  a_accept_enters : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_i && !stall_o) |=> valid_q[0])
    else $error("accepted word lost at pipeline entry");

  // once the output word is taken, the word behind it moves up
  a_drain : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && !stall_i) |=> (valid_o == $past(valid_q[NumStg-2])))
    else $error("output stage did not advance after hand-over");

  // free-running receiver never back-pressures the sender
  a_no_stall_free : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !stall_i |-> !stall_o)
    else $error("stall_o raised without receiver stall");

endmodule

### tb/euler_angles_to_basis_vectors_tb.sv
// Self-checking bench for euler_angles_to_basis_vectors: angle words in, basis words checked.
// Depends on eabv_pkg (word types, NumStg) and the RTL top level; nothing else.
`timescale 1ns / 1ps

module euler_angles_to_basis_vectors_tb;
  import eabv_pkg::*;

  localparam int ResetCycles  = 8;
  localparam int RandPerPhase = 475;
  // Cycles without any word moving on either side before the run is abandoned. The longest
  // gap or stall at 77 percent, plus the 11 pipeline stages, stays well under this limit.
  localparam int StuckLimit   = 2000;
  localparam int DrainCycles  = NumStg + 8;
  localparam int NumFields    = 9;
  localparam int NumCorners   = 14;

  // Angle arithmetic, Q30 throughout.
  localparam int     UnitsHalf  = 11520;   // 180 degrees in 1/64 degree
  localparam longint RadPerUnit = 292818;  // pi/11520 in Q30
  localparam longint SinK3      = 8132786;
  localparam longint SinK2      = -178055431;
  localparam longint SinK1      = 1073496375;
  localparam longint CosK3      = 39953211;
  localparam longint CosK2      = -532997206;
  localparam longint CosK1      = 1073290332;

  logic clk_i   = 1'b0;
  logic rst_ni  = 1'b0;
  logic valid_i = 1'b0;
  logic stall_i = 1'b0;
  in_t  in_i    = '0;
  logic stall_o;
  logic valid_o;
  out_t out_o;

  in_t  angle_backlog[$];   // words waiting for the driver
  out_t basis_due[$];       // predicted basis words, oldest first

  int send_idle    = 0;     // percent of cycles the sender holds back
  int recv_stall   = 0;     // percent of cycles the receiver stalls
  int words_in     = 0;
  int words_out    = 0;
  int mismatches   = 0;
  int stuck_cycles = 0;

  string field_names[NumFields] = '{"fwd_x", "fwd_y", "fwd_z", "right_x", "right_y",
                                    "right_z", "up_x", "up_y", "up_z"};

  // Range ends, reduction ties at +-90/270/450 degrees, exact odd multiples of a half
  // turn, and values one unit either side of a tie.
  logic signed [15:0] corner_vals[NumCorners] = '{16'sd0, 16'sd32767, -16'sd32768,
                                                  16'sd5760, -16'sd5760, 16'sd17280,
                                                  -16'sd17280, 16'sd28800, -16'sd28800,
                                                  16'sd11520, -16'sd11520, 16'sd5759,
                                                  -16'sd5761, 16'sd2880};

  euler_angles_to_basis_vectors dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (valid_i),
    .stall_o (stall_o),
    .in_i    (in_i),
    .valid_o (valid_o),
    .stall_i (stall_i),
    .out_o   (out_o)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  // Shift right with rounding half away from zero.
  function automatic longint shr_round(input longint p, input int s);
    longint half;
    half = longint'(1) << (s - 1);
    if (p >= 0) return (p + half) >>> s;
    return -((-p + half) >>> s);
  endfunction

  function automatic longint qmul30(input longint a, input longint b);
    return shr_round(a * b, 30);
  endfunction

  // Sine and cosine of one angle: reduce by the nearest half turn (ties away from zero),
  // polynomial on the remainder, both negated for an odd number of half turns.
  function automatic void angle_trig(input logic signed [15:0] ang,
                                     output longint sn, output longint cs);
    int     a;
    int     k;
    longint x;
    longint x2;
    longint t;
    a = ang;
    if (a >= 0) k = (a + UnitsHalf / 2) / UnitsHalf;
    else        k = -((-a + UnitsHalf / 2) / UnitsHalf);
    x  = longint'(a - k * UnitsHalf) * RadPerUnit;
    x2 = qmul30(x, x);
    t  = SinK2 + qmul30(SinK3, x2);
    t  = SinK1 + qmul30(x2, t);
    sn = qmul30(x, t);
    t  = CosK2 + qmul30(CosK3, x2);
    cs = CosK1 + qmul30(x2, t);
    if ((k % 2) != 0) begin
      sn = -sn;
      cs = -cs;
    end
  endfunction

  // Q30 to Q2.14 with rounding and saturation at the range ends.
  function automatic logic signed [15:0] q30_to_q14(input longint v);
    longint r;
    r = shr_round(v, 16);
    if (r > 32767) r = 32767;
    else if (r < -32768) r = -32768;
    return 16'(r);
  endfunction

  function automatic out_t predict_basis(input in_t w);
    longint sp, cp, sy, cy, sr, cr;
    longint spcy, spsy;
    out_t   b;
    angle_trig(w.pitch_deg, sp, cp);
    angle_trig(w.yaw_deg, sy, cy);
    angle_trig(w.roll_deg, sr, cr);
    spcy      = qmul30(sp, cy);
    spsy      = qmul30(sp, sy);
    b.fwd_x   = q30_to_q14(qmul30(cp, cy));
    b.fwd_y   = q30_to_q14(qmul30(cp, sy));
    b.fwd_z   = q30_to_q14(-sp);
    b.right_x = q30_to_q14(-qmul30(sr, spcy) + qmul30(cr, sy));
    b.right_y = q30_to_q14(-qmul30(sr, spsy) - qmul30(cr, cy));
    b.right_z = q30_to_q14(-qmul30(sr, cp));
    b.up_x    = q30_to_q14(qmul30(cr, spcy) + qmul30(sr, sy));
    b.up_y    = q30_to_q14(qmul30(cr, spsy) - qmul30(sr, cy));
    b.up_z    = q30_to_q14(qmul30(cr, cp));
    return b;
  endfunction

  // Random angle: mostly any 16-bit value, the rest close to reduction ties and
  // to quarter turns where the sine or cosine crosses zero or peaks.
  function automatic logic signed [15:0] rand_angle();
    int pick;
    int k;
    int d;
    pick = $urandom_range(99);
    d    = int'($urandom_range(4)) - 2;
    if (pick < 60) return 16'($urandom);
    if (pick < 85) begin
      k = int'($urandom_range(5)) - 3;
      return 16'(k * UnitsHalf + UnitsHalf / 2 + d);
    end
    k = int'($urandom_range(10)) - 5;
    return 16'(k * (UnitsHalf / 2) + d);
  endfunction

  // ---------------------------------------------------------------------------
  // Driver: loads a new word only when the current one has moved or none is up.
  // Each accepted word is predicted on the spot.
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (valid_i && !stall_o) begin
        basis_due.push_back(predict_basis(in_i));
        words_in++;
      end
      if (!valid_i || !stall_o) begin
        if (angle_backlog.size() != 0 && $urandom_range(99) >= send_idle) begin
          in_i    <= angle_backlog.pop_front();
          valid_i <= 1'b1;
        end else begin
          valid_i <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: checks each accepted basis word against the oldest prediction,
  // drives the receiver stall and runs the watchdog.
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin : monitor
    out_t want;
    logic signed [15:0] exp_f;
    logic signed [15:0] got_f;
    if (rst_ni) begin
      if (valid_o && !stall_i) begin
        words_out++;
        if (basis_due.size() == 0) begin
          mismatches++;
          $display("%0t: basis word with nothing predicted, expected none got %h", $time,
                   out_o);
        end else begin
          want = basis_due.pop_front();
          for (int f = 0; f < NumFields; f++) begin
            exp_f = want[16 * (NumFields - f) - 1 -: 16];
            got_f = out_o[16 * (NumFields - f) - 1 -: 16];
            if (exp_f !== got_f) begin
              mismatches++;
              $display("%0t: word %0d %s expected %0d got %0d", $time, words_out,
                       field_names[f], exp_f, got_f);
            end
          end
        end
      end
      stall_i <= ($urandom_range(99) < recv_stall);

      if ((valid_i && !stall_o) || (valid_o && !stall_i)) begin
        stuck_cycles <= 0;
      end else if (stuck_cycles >= StuckLimit) begin
        $display("%0t: no word moved for %0d cycles, %0d predictions outstanding", $time,
                 StuckLimit, basis_due.size());
        $display("Mismatches found");
        $finish;
      end else begin
        stuck_cycles <= stuck_cycles + 1;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus: directed corners, then four flow-control phases of random words.
  // Settings change at the falling edge so the clocked blocks never race them.
  // ---------------------------------------------------------------------------
  initial begin : stimulus
    in_t w;

    repeat (ResetCycles) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Every corner value reaches every field.
    for (int i = 0; i < NumCorners; i++) begin
      w.pitch_deg = corner_vals[i];
      w.yaw_deg   = corner_vals[(i + 5) % NumCorners];
      w.roll_deg  = corner_vals[(i + 9) % NumCorners];
      angle_backlog.push_back(w);
    end
    angle_backlog.push_back('{16'sd0, 16'sd0, 16'sd0});
    angle_backlog.push_back('{16'sd2880, 16'sd2880, 16'sd2880});
    angle_backlog.push_back('{-16'sd32768, -16'sd32768, -16'sd32768});
    angle_backlog.push_back('{16'sd32767, 16'sd32767, 16'sd32767});
    angle_backlog.push_back('{16'sd5760, -16'sd5760, 16'sd17280});

    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin send_idle = 0;  recv_stall = 0;  end
        1: begin send_idle = 77; recv_stall = 0;  end
        2: begin send_idle = 0;  recv_stall = 77; end
        default: begin send_idle = 37; recv_stall = 37; end
      endcase
      for (int i = 0; i < RandPerPhase; i++) begin
        w.pitch_deg = rand_angle();
        w.yaw_deg   = rand_angle();
        w.roll_deg  = rand_angle();
        angle_backlog.push_back(w);
      end
      while (angle_backlog.size() != 0 || valid_i || basis_due.size() != 0)
        @(negedge clk_i);
    end

    // Let the pipeline settle; anything arriving now has no prediction.
    repeat (DrainCycles) @(negedge clk_i);
    if (basis_due.size() != 0) begin
      mismatches += basis_due.size();
      $display("%0t: %0d predicted basis words never arrived", $time, basis_due.size());
    end

    $display("Sent %0d angle words (corners, reduction ties, random) and checked %0d basis",
             words_in, words_out);
    $display("words under free flow, sender gaps, receiver stalls and both together.");
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
